// ===== hw/rtl/wsr_pkg.sv =====
// ----------------------------------------------------------------------------
// wsr_pkg
// Shared widths, constants, controller types and the modular reduce helper
// for the windowed sum recurrence block.
// ----------------------------------------------------------------------------
package wsr_pkg;

	localparam int LengthW = 20;
	localparam int WindowW = 11;
	localparam int CountW = 30;

	localparam int Modulus = 1000000000;
	localparam int MaxWindowDefault = 1024;

	// signed width that holds (-Modulus, 3*Modulus)
	localparam int SumW = CountW + 3;
	localparam logic signed [SumW-1:0] ModS = SumW'(Modulus);
	localparam logic signed [SumW-1:0] Mod2S = SumW'(2 * 64'(Modulus));

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DONE
	} wsr_state_t;

	typedef struct packed {
		logic load;
		logic step;
		logic finish;
	} wsr_cmd_t;

	typedef struct packed {
		logic rem_zero;
	} wsr_status_t;

	// bring a value in (-Modulus, 3*Modulus) back to [0, Modulus)
	function automatic logic [CountW-1:0] mod_reduce(input logic signed [SumW-1:0] d);
		logic signed [SumW-1:0] r;
		if (d < 0) begin
			r = d + ModS;
		end else if (d < ModS) begin
			r = d;
		end else if (d < Mod2S) begin
			r = d - ModS;
		end else begin
			r = d - Mod2S;
		end
		return r[CountW-1:0];
	endfunction

endpackage

// ===== hw/rtl/wsr_req_if.sv =====
// ----------------------------------------------------------------------------
// wsr_req_if
// Request channel: term index and window, valid/ready handshake.
// ----------------------------------------------------------------------------
interface wsr_req_if;
	logic                          valid;
	logic                          ready;
	logic [wsr_pkg::LengthW-1:0]   length;
	logic [wsr_pkg::WindowW-1:0]   window;

	modport source (output valid, output length, output window, input ready);
	modport sink (input valid, input length, input window, output ready);
endinterface

// ===== hw/rtl/wsr_rsp_if.sv =====
// ----------------------------------------------------------------------------
// wsr_rsp_if
// Response channel: one term value per request, valid/ready handshake.
// ----------------------------------------------------------------------------
interface wsr_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [wsr_pkg::CountW-1:0]    count;

	modport source (output valid, output count, input ready);
	modport sink (input valid, input count, output ready);
endinterface

// ===== hw/rtl/windowed_sum_recurrence_mod.sv =====
// ----------------------------------------------------------------------------
// windowed_sum_recurrence_mod
// A request runs its recurrence steps, one per cycle, then its term goes to the
// output register once that is free; a new request is taken only when idle.
// Steps are bound by the running-sum update and the term ring read and write.
// A new request is taken while the previous response waits in its register.
// Reset clears the sequencer and response valid; the term ring is not cleared.
// ----------------------------------------------------------------------------
module windowed_sum_recurrence_mod #(
	parameter int MaxWindow = wsr_pkg::MaxWindowDefault
) (
	input  logic    clk,
	input  logic    arst_n,
	wsr_req_if.sink   req,
	wsr_rsp_if.source rsp
);
	import wsr_pkg::*;

	wsr_cmd_t    cmd;
	wsr_status_t status;

	wsr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.status    (status),
		.cmd       (cmd)
	);

	wsr_datapath #(
		.MaxWindow (MaxWindow)
	) u_datapath (
		.clk    (clk),
		.length (req.length),
		.window (req.window),
		.cmd    (cmd),
		.status (status),
		.count  (rsp.count)
	);

endmodule

// ===== hw/rtl/wsr_ctrl.sv =====
// ----------------------------------------------------------------------------
// wsr_ctrl
// Sequencer: takes a request, runs one recurrence step per cycle until the
// step count is used up, then hands the term to the output register.
// ----------------------------------------------------------------------------
module wsr_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_ready,
	output logic                 rsp_valid,
	input  logic                 rsp_ready,
	input  wsr_pkg::wsr_status_t status,
	output wsr_pkg::wsr_cmd_t    cmd
);
	import wsr_pkg::*;

	wsr_state_t state_q, state_d;
	logic       rsp_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		req_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				if (status.rem_zero) begin
					state_d = ST_DONE;
				end else begin
					cmd.step = 1'b1;
				end
			end
			ST_DONE: begin
				// wait for the output register to drain
				if (!rsp_valid_q || rsp_ready) begin
					cmd.finish = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign rsp_valid = rsp_valid_q;

endmodule

// ===== hw/rtl/wsr_datapath.sv =====
// ----------------------------------------------------------------------------
// wsr_datapath
// Term ring memory, running sum, step counters and output register.
// One recurrence step per step command.
// ----------------------------------------------------------------------------
module wsr_datapath #(
	parameter int MaxWindow = wsr_pkg::MaxWindowDefault
) (
	input  logic                         clk,
	input  logic [wsr_pkg::LengthW-1:0]  length,
	input  logic [wsr_pkg::WindowW-1:0]  window,
	input  wsr_pkg::wsr_cmd_t            cmd,
	output wsr_pkg::wsr_status_t         status,
	output logic [wsr_pkg::CountW-1:0]   count
);
	import wsr_pkg::*;

	localparam int Depth = MaxWindow + 1;
	localparam int PtrW = $clog2(Depth);
	localparam int Two = 2 % Depth;

	logic [CountW-1:0]  ring_q [Depth];
	logic [CountW-1:0]  rd_q;

	logic [LengthW-1:0] rem_q;
	logic [PtrW-1:0]    dbl_q;
	logic               k_is0_q, k_is1_q;
	logic [CountW-1:0]  prev_q, sum_q, count_q;
	logic [PtrW-1:0]    wp_q, rp_q;

	logic [PtrW-1:0]    k_sat;
	logic [PtrW:0]      rp_init_raw;
	logic [PtrW-1:0]    rp_init;
	logic [PtrW-1:0]    wp_inc, rp_inc;

	logic signed [SumW-1:0] prev_x, sum_x, sub_x;
	logic [CountW-1:0]  t_new, sum_new;

	// window saturates to MaxWindow, one less than the ring depth
	always_comb begin
		if (int'(window) > MaxWindow) begin
			k_sat = PtrW'(MaxWindow);
		end else begin
			k_sat = PtrW'(window);
		end
		// read pointer runs one step ahead: slot (2 - k) mod depth
		rp_init_raw = (PtrW+1)'(Depth) + (PtrW+1)'(Two) - (PtrW+1)'(k_sat);
		if (rp_init_raw >= (PtrW+1)'(Depth)) begin
			rp_init_raw = rp_init_raw - (PtrW+1)'(Depth);
		end
		rp_init = rp_init_raw[PtrW-1:0];
	end

	assign wp_inc = (wp_q == PtrW'(Depth - 1)) ? '0 : wp_q + 1'b1;
	assign rp_inc = (rp_q == PtrW'(Depth - 1)) ? '0 : rp_q + 1'b1;

	always_comb begin
		prev_x = SumW'(prev_q);
		sum_x = SumW'(sum_q);
		// window of one reads the slot written last step; empty window subtracts zero
		if (k_is0_q) begin
			sub_x = '0;
		end else if (k_is1_q) begin
			sub_x = prev_x;
		end else begin
			sub_x = SumW'(rd_q);
		end
		if (dbl_q != '0) begin
			t_new = mod_reduce(prev_x + prev_x);
			sum_new = mod_reduce(sum_x + prev_x + prev_x);
		end else begin
			t_new = sum_q;
			sum_new = mod_reduce(sum_x + sum_x - sub_x);
		end
	end

	// term zero is one for every item
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ring_q[PtrW'(0)] <= CountW'(1);
		end else if (cmd.step) begin
			ring_q[wp_q] <= t_new;
		end
	end

	always_ff @(posedge clk) begin
		rd_q <= ring_q[rp_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rem_q <= length;
			dbl_q <= k_sat;
			k_is0_q <= (k_sat == PtrW'(0));
			k_is1_q <= (k_sat == PtrW'(1));
			prev_q <= CountW'(1);
			sum_q <= '0;
			wp_q <= PtrW'(1);
			rp_q <= rp_init;
		end else if (cmd.step) begin
			rem_q <= rem_q - 1'b1;
			if (dbl_q != '0) begin
				dbl_q <= dbl_q - 1'b1;
			end
			prev_q <= t_new;
			sum_q <= sum_new;
			wp_q <= wp_inc;
			rp_q <= rp_inc;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			count_q <= prev_q;
		end
	end

	assign status.rem_zero = (rem_q == '0);
	assign count = count_q;

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives term requests into the windowed sum recurrence block and checks
// every response against a typed-in count or a behavioral predictor: a short
// table of corner requests, then random requests, mostly short, under random
// idling on both channels.
// ----------------------------------------------------------------------------
module testbench;

	import wsr_pkg::*;

	localparam int MaxWin = MaxWindowDefault;
	localparam int RingDepth = MaxWin + 1;
	localparam int unsigned Mod = Modulus;
	localparam int RandomItems = 80;
	localparam int DrainCycles = 16;
	localparam longint CycleLimit = 20_000_000;
	localparam int TableSize = 20;

	typedef struct {
		logic [LengthW-1:0] length;
		logic [WindowW-1:0] window;
		bit                 known;
		logic [CountW-1:0]  count;
	} request_row_t;

	logic clk;
	logic arst_n;

	wsr_req_if req_ch ();
	wsr_rsp_if rsp_ch ();

	windowed_sum_recurrence_mod uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	logic [CountW-1:0] pending_counts[$];
	int errors = 0;
	longint cycle_count = 0;

	// corner requests; count typed in only where it is plain
	request_row_t corner_rows [TableSize] = '{
		'{20'd0,       11'd1,    1'b1, 30'd1},
		'{20'd0,       11'd1024, 1'b1, 30'd1},
		'{20'd0,       11'd0,    1'b1, 30'd1},
		'{20'd7,       11'd0,    1'b1, 30'd0},
		'{20'd1,       11'd1,    1'b1, 30'd2},
		'{20'd5,       11'd10,   1'b1, 30'd32},
		'{20'd10,      11'd10,   1'b1, 30'd1024},
		'{20'd29,      11'd1024, 1'b1, 30'd536870912},
		'{20'd30,      11'd30,   1'b1, 30'd73741824},
		'{20'd64,      11'd1024, 1'b1, 30'd709551616},
		'{20'd2,       11'd1,    1'b0, 30'd0},
		'{20'd40,      11'd2,    1'b0, 30'd0},
		'{20'd100,     11'd3,    1'b0, 30'd0},
		'{20'd50,      11'd1023, 1'b0, 30'd0},
		'{20'd1025,    11'd1024, 1'b0, 30'd0},
		'{20'd3000,    11'd1024, 1'b0, 30'd0},
		'{20'd1500,    11'd1025, 1'b0, 30'd0},
		'{20'd1200,    11'd2047, 1'b0, 30'd0},
		'{20'd2100,    11'd1000, 1'b0, 30'd0},
		'{20'd1048575, 11'd37,   1'b0, 30'd0}
	};

	// term n of the windowed sum sequence, modulo one billion
	function automatic logic [CountW-1:0] kbonacci_term(input logic [LengthW-1:0] n,
			input logic [WindowW-1:0] win);
		int unsigned hist [RingDepth];
		int unsigned k;
		int unsigned sum;
		int unsigned prev;
		int unsigned t;
		int unsigned leaving;
		k = (win > MaxWin) ? MaxWin : win;
		sum = 0;
		prev = 1;
		hist[0] = 1;
		for (int unsigned i = 1; i <= n; i++) begin
			if (i <= k) begin
				t = prev + prev;
				if (t >= Mod) t -= Mod;
				hist[i % RingDepth] = t;
				sum += t;
				if (sum >= Mod) sum -= Mod;
			end else begin
				t = sum;
				hist[i % RingDepth] = t;
				sum += t;
				if (sum >= Mod) sum -= Mod;
				leaving = hist[(i - k) % RingDepth];
				sum = (sum >= leaving) ? sum - leaving : sum + Mod - leaving;
			end
			prev = t;
		end
		return prev[CountW-1:0];
	endfunction

	// mostly zero or short, now and then long
	function automatic int unsigned idle_gap(input bit quiet);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (quiet || r < 45) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 96) return $urandom_range(4, 12);
		return $urandom_range(20, 80);
	endfunction

	function automatic logic [WindowW-1:0] pick_window();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 45) return WindowW'($urandom_range(1, 16));
		if (r < 88) return WindowW'($urandom_range(1, MaxWin));
		if (r < 92) return WindowW'(MaxWin);
		if (r < 95) return WindowW'(1);
		if (r == 99) return '0;
		return WindowW'($urandom_range(MaxWin + 1, (1 << WindowW) - 1));
	endfunction

	// short lengths dominate; a few reach well past the window
	function automatic logic [LengthW-1:0] pick_length(input logic [WindowW-1:0] win);
		int unsigned r;
		int unsigned k;
		r = $urandom_range(0, 99);
		k = (win > MaxWin) ? MaxWin : win;
		if (r < 60) return LengthW'($urandom_range(0, 300));
		if (r < 85) return LengthW'(k + $urandom_range(0, 1200));
		if (r < 97) return LengthW'($urandom_range(300, 4000));
		return LengthW'($urandom_range(4000, 20000));
	endfunction

	task automatic send_request(input logic [LengthW-1:0] len, input logic [WindowW-1:0] win,
			input logic [CountW-1:0] count, input int unsigned gap);
		if (gap > 0) begin
			@(negedge clk);
			req_ch.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		req_ch.valid  <= 1'b1;
		req_ch.length <= len;
		req_ch.window <= win;
		do @(posedge clk); while (!req_ch.ready);
		pending_counts = {pending_counts, count};
	endtask

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// stimulus and verdict
	initial begin
		logic [LengthW-1:0] len;
		logic [WindowW-1:0] win;
		logic [CountW-1:0] count;
		bit quiet;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.length = '0;
		req_ch.window = WindowW'(1);
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		foreach (corner_rows[i]) begin
			len = corner_rows[i].length;
			win = corner_rows[i].window;
			count = corner_rows[i].known ? corner_rows[i].count : kbonacci_term(len, win);
			send_request(len, win, count, idle_gap(1'b0));
		end

		for (int i = 0; i < RandomItems; i++) begin
			quiet = ((i / 10) % 4) == 3;
			win = pick_window();
			len = pick_length(win);
			send_request(len, win, kbonacci_term(len, win), idle_gap(quiet));
		end
		@(negedge clk);
		req_ch.valid <= 1'b0;

		while (pending_counts.size() != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
		if (errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	// response stalls, with calm stretches of steady ready
	initial begin
		bit quiet;
		int unsigned gap;
		rsp_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			quiet = ($urandom_range(0, 3) == 0);
			repeat ($urandom_range(10, 40)) begin
				gap = idle_gap(quiet);
				if (gap > 0) begin
					@(negedge clk);
					rsp_ch.ready <= 1'b0;
					repeat (gap - 1) @(negedge clk);
				end
				@(negedge clk);
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	// response check
	initial begin
		logic [CountW-1:0] want;
		forever begin
			@(posedge clk);
			if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
				if (pending_counts.size() == 0) begin
					$display("%0t: unexpected item, expected none, actual count %0d",
						$time, rsp_ch.count);
					errors++;
				end else begin
					want = pending_counts.pop_front();
					if (rsp_ch.count !== want) begin
						$display("%0t: count mismatch, expected %0d, actual %0d",
							$time, want, rsp_ch.count);
						errors++;
					end
				end
			end
		end
	end

	initial begin
		while (cycle_count < CycleLimit) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("%0t: timeout, %0d items still expected", $time, pending_counts.size());
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ===== windowed_sum_recurrence_mod.f =====
hw/rtl/wsr_pkg.sv
hw/rtl/wsr_req_if.sv
hw/rtl/wsr_rsp_if.sv
hw/rtl/wsr_ctrl.sv
hw/rtl/wsr_datapath.sv
hw/rtl/windowed_sum_recurrence_mod.sv
tb/testbench.sv
